### rtl/rdq_pkg.sv
// Shared types and codes for the restricted double-ended queue.
// Holds the request and response word layouts and the operation, status and mode codes.
// Used by rtl/restricted_double_ended_queue_core.sv and rtl/rdq_checker.sv.
`default_nettype none

package rdq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_REAR   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_FORBIDDEN = 2'd3
	} status_t;

	// Mode value three is treated as unrestricted.
	typedef enum logic [1:0] {
		MODE_FREE       = 2'd0,
		MODE_INPUT_RESTR  = 2'd1,
		MODE_OUTPUT_RESTR = 2'd2,
		MODE_SPARE      = 2'd3
	} mode_t;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W  = 5;

	typedef struct packed {
		op_t                      op;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/restricted_double_ended_queue_core.sv
// Response: a push or a refused request has its response word registered when it is accepted;
// a successful pop registers the entry memory read first and then the response word.
// Throughput: one push or refused request per cycle while out_stall is low; a successful pop
// holds in_stall until the data from the single memory read port reaches the response word.
// Reset: arst_n clears head, tail, count, mode and the valid flags; entry memory is not cleared.
// Depends on rtl/rdq_pkg.sv.
`default_nettype none

module restricted_double_ended_queue_core #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire rdq_pkg::req_t in_data,
	output logic              out_valid,
	input  wire logic         out_stall,
	output rdq_pkg::rsp_t     out_data,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_data
);

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - IW'(1);
	endfunction

	logic [rdq_pkg::WORD_W-1:0] mem [DEPTH];

	rdq_pkg::mode_t             mode_q;
	logic [IW-1:0]              head_q;
	logic [IW-1:0]              tail_q;
	logic [CW-1:0]              count_q;
	logic                       out_valid_q;
	rdq_pkg::rsp_t              out_data_q;
	logic                       pend_s1;
	rdq_pkg::status_t           status_s1;
	logic [rdq_pkg::OCC_W-1:0]  occ_s1;
	logic [rdq_pkg::WORD_W-1:0] rd_data_s1;

	logic                       accept;
	logic                       is_push;
	logic                       forbidden;
	rdq_pkg::status_t           status_c;
	logic                       ok;
	logic [IW-1:0]              head_nx;
	logic [IW-1:0]              tail_nx;
	logic [CW-1:0]              count_nx;
	logic [IW-1:0]              mem_idx;
	logic                       wr_en;
	logic                       rd_en;

	assign in_stall  = pend_s1 || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		is_push   = (in_data.op == rdq_pkg::OP_PUSH_REAR) ||
			(in_data.op == rdq_pkg::OP_PUSH_FRONT);
		forbidden = (mode_q == rdq_pkg::MODE_INPUT_RESTR &&
				in_data.op == rdq_pkg::OP_PUSH_FRONT) ||
			(mode_q == rdq_pkg::MODE_OUTPUT_RESTR && in_data.op == rdq_pkg::OP_POP_REAR);

		// Mode check first, then full or empty.
		status_c = rdq_pkg::ST_DONE;
		if (forbidden) begin
			status_c = rdq_pkg::ST_FORBIDDEN;
		end else if (is_push && count_q == FULL_CNT) begin
			status_c = rdq_pkg::ST_FULL;
		end else if (!is_push && count_q == '0) begin
			status_c = rdq_pkg::ST_EMPTY;
		end
		ok = (status_c == rdq_pkg::ST_DONE);

		head_nx = head_q;
		tail_nx = tail_q;
		mem_idx = tail_q;
		unique case (in_data.op)
			rdq_pkg::OP_PUSH_REAR: begin
				mem_idx = tail_q;
				tail_nx = idx_next(tail_q);
			end
			rdq_pkg::OP_PUSH_FRONT: begin
				mem_idx = idx_prev(head_q);
				head_nx = idx_prev(head_q);
			end
			rdq_pkg::OP_POP_REAR: begin
				mem_idx = idx_prev(tail_q);
				tail_nx = idx_prev(tail_q);
			end
			rdq_pkg::OP_POP_FRONT: begin
				mem_idx = head_q;
				head_nx = idx_next(head_q);
			end
			default: begin
				mem_idx = tail_q;
			end
		endcase

		if (!ok) begin
			count_nx = count_q;
		end else if (is_push) begin
			count_nx = count_q + CW'(1);
		end else begin
			count_nx = count_q - CW'(1);
		end

		wr_en = accept && ok && is_push;
		rd_en = accept && ok && !is_push;
	end

	// Entry memory: one port, pushes and pops never share a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[mem_idx] <= in_data.value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[mem_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rdq_pkg::MODE_FREE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= rdq_pkg::mode_t'(cfg_data);
			end
			if (accept) begin
				if (ok) begin
					head_q  <= head_nx;
					tail_q  <= tail_nx;
					count_q <= count_nx;
				end
				// A pop waits in pend_s1 for its registered read data; the output is free meanwhile.
				pend_s1     <= rd_en;
				out_valid_q <= !rd_en;
			end else if (pend_s1) begin
				pend_s1     <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			occ_s1    <= rdq_pkg::OCC_W'(count_nx);
			if (!rd_en) begin
				out_data_q.popped_value <= '0;
				out_data_q.status       <= status_c;
				out_data_q.occupancy    <= rdq_pkg::OCC_W'(count_nx);
			end
		end else if (pend_s1) begin
			out_data_q.popped_value <= rd_data_s1;
			out_data_q.status       <= status_s1;
			out_data_q.occupancy    <= occ_s1;
		end
	end

endmodule

`default_nettype wire

### rtl/rdq_checker.sv
// Port-level checks for the restricted double-ended queue response channel.
// Bound to restricted_double_ended_queue_core; depends on rtl/rdq_pkg.sv.
`default_nettype none

module rdq_checker #(
	parameter int unsigned DEPTH = 16
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire rdq_pkg::rsp_t out_data
);

	// Hold a stalled response word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled response word changed");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != rdq_pkg::ST_DONE |-> out_data.popped_value == '0)
		else $error("refused request returned a non-zero word");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == rdq_pkg::ST_EMPTY |-> out_data.occupancy == '0)
		else $error("empty refusal with non-zero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == rdq_pkg::ST_FULL |->
			out_data.occupancy == rdq_pkg::OCC_W'(DEPTH))
		else $error("full refusal with occupancy below depth");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && DEPTH < 32 |-> out_data.occupancy <= DEPTH)
		else $error("occupancy above depth");

endmodule

bind restricted_double_ended_queue_core rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

### tb/rdq_queue_checker.sv
// Response checker for the restricted double-ended queue: watches the request,
// response and mode channels, keeps its own ring of words and compares every response.
// Depends on rtl/rdq_pkg.sv.
`timescale 1ns / 100ps

module rdq_queue_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  rdq_pkg::req_t  in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  rdq_pkg::rsp_t  out_data,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [1:0]     cfg_data,
	output int             errors,
	output int             awaiting
);

	logic signed [rdq_pkg::WORD_W-1:0] slot_word [DEPTH];
	int unsigned    front_slot;
	int unsigned    back_slot;
	int unsigned    held;
	rdq_pkg::mode_t mode_q;
	rdq_pkg::rsp_t  due_rsp [$];
	rdq_pkg::rsp_t  want;
	rdq_pkg::rsp_t  got;
	int             reported;

	// Apply one request to the ring and work out the response it earns.
	task automatic serve_request(input rdq_pkg::req_t r, output rdq_pkg::rsp_t rsp);
		logic blocked;
		blocked = (mode_q == rdq_pkg::MODE_INPUT_RESTR && r.op == rdq_pkg::OP_PUSH_FRONT) ||
			(mode_q == rdq_pkg::MODE_OUTPUT_RESTR && r.op == rdq_pkg::OP_POP_REAR);
		rsp.popped_value = '0;
		rsp.status = rdq_pkg::ST_DONE;
		if (blocked) begin
			rsp.status = rdq_pkg::ST_FORBIDDEN;
		end else if (r.op == rdq_pkg::OP_PUSH_REAR || r.op == rdq_pkg::OP_PUSH_FRONT) begin
			if (held >= DEPTH) begin
				rsp.status = rdq_pkg::ST_FULL;
			end else if (r.op == rdq_pkg::OP_PUSH_REAR) begin
				slot_word[back_slot] = r.value;
				back_slot = (back_slot + 1) % DEPTH;
				held++;
			end else begin
				front_slot = (front_slot + DEPTH - 1) % DEPTH;
				slot_word[front_slot] = r.value;
				held++;
			end
		end else if (held == 0) begin
			rsp.status = rdq_pkg::ST_EMPTY;
		end else if (r.op == rdq_pkg::OP_POP_REAR) begin
			back_slot = (back_slot + DEPTH - 1) % DEPTH;
			rsp.popped_value = slot_word[back_slot];
			held--;
		end else begin
			rsp.popped_value = slot_word[front_slot];
			front_slot = (front_slot + 1) % DEPTH;
			held--;
		end
		rsp.occupancy = held[rdq_pkg::OCC_W-1:0];
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			front_slot = 0;
			back_slot = 0;
			held = 0;
			mode_q = rdq_pkg::MODE_FREE;
			due_rsp.delete();
			errors = 0;
			reported = 0;
			awaiting = 0;
		end else begin
			// A request taken at the same edge as a mode write still sees the old mode.
			if (in_valid && !in_stall) begin
				serve_request(in_data, want);
				due_rsp.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				mode_q = rdq_pkg::mode_t'(cfg_data);
			if (out_valid && !out_stall) begin
				got = out_data;
				if (due_rsp.size() == 0) begin
					errors++;
					if (reported < 10)
						$display("unexpected response word: value %0d status %0d occupancy %0d",
							got.popped_value, got.status, got.occupancy);
					reported++;
				end else begin
					want = due_rsp.pop_front();
					if (got.popped_value !== want.popped_value || got.status !== want.status ||
							got.occupancy !== want.occupancy) begin
						errors++;
						if (reported < 10)
							$display({"mismatch: expected value %0d status %0d occupancy %0d,",
								" got value %0d status %0d occupancy %0d"},
								want.popped_value, want.status, want.occupancy,
								got.popped_value, got.status, got.occupancy);
						reported++;
					end
				end
			end
			awaiting = due_rsp.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the restricted double-ended queue testbench: clock, reset, request and mode
// stimulus, response stalls and the verdict. Depends on rtl/rdq_pkg.sv,
// rtl/restricted_double_ended_queue_core.sv and tb/rdq_queue_checker.sv.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned QDEPTH = 16;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int PHASES = 13;
	localparam int PHASE_ITEMS = 146;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	rdq_pkg::req_t in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	rdq_pkg::rsp_t out_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_data = '0;

	int fail_count;
	int awaiting;
	int send_gap_pct = 0;
	int stall_gap_pct = 0;
	int stall_left = 0;
	int cycle_count = 0;

	restricted_double_ended_queue_core #(
		.DEPTH(QDEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	rdq_queue_checker #(
		.DEPTH(QDEPTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(fail_count),
		.awaiting(awaiting)
	);

	always #4 clk = ~clk;

	// Stall the response side in bursts of random length.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_gap_pct > 0 && $urandom_range(0, 99) < stall_gap_pct) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("restricted_double_ended_queue_core test failed");
			$finish;
		end
	end

	function automatic logic signed [rdq_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic rdq_pkg::op_t pick_op(int push_pct);
		logic at_front;
		at_front = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < push_pct)
			return at_front ? rdq_pkg::OP_PUSH_FRONT : rdq_pkg::OP_PUSH_REAR;
		return at_front ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_POP_REAR;
	endfunction

	// Offer one request word and hold it until accepted; returns at a falling edge.
	task automatic send_item(input rdq_pkg::op_t op,
			input logic signed [rdq_pkg::WORD_W-1:0] value);
		if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.op <= op;
		in_data.value <= value;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Drain outstanding responses, then write the mode register.
	task automatic write_mode(input rdq_pkg::mode_t m);
		in_valid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int             push_pct;
		int             run_left;
		rdq_pkg::mode_t phase_mode;
		push_pct = 50;
		run_left = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty pops, extremes, and a single-word pop from each end.
		send_item(rdq_pkg::OP_POP_REAR, pick_word());
		send_item(rdq_pkg::OP_POP_FRONT, pick_word());
		send_item(rdq_pkg::OP_PUSH_REAR, 32'sh7FFF_FFFF);
		send_item(rdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
		send_item(rdq_pkg::OP_POP_REAR, pick_word());
		send_item(rdq_pkg::OP_POP_REAR, pick_word());
		send_item(rdq_pkg::OP_PUSH_FRONT, '1);
		send_item(rdq_pkg::OP_POP_FRONT, pick_word());
		// Fill from both ends, then push on a full queue.
		for (int i = 0; i < QDEPTH; i++)
			send_item((i % 2) ? rdq_pkg::OP_PUSH_FRONT : rdq_pkg::OP_PUSH_REAR,
				(i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA);
		send_item(rdq_pkg::OP_PUSH_FRONT, pick_word());
		send_item(rdq_pkg::OP_PUSH_REAR, pick_word());
		// Mode check comes before the full check.
		write_mode(rdq_pkg::MODE_INPUT_RESTR);
		send_item(rdq_pkg::OP_PUSH_FRONT, pick_word());
		send_item(rdq_pkg::OP_POP_FRONT, pick_word());
		write_mode(rdq_pkg::MODE_OUTPUT_RESTR);
		send_item(rdq_pkg::OP_POP_REAR, pick_word());
		send_item(rdq_pkg::OP_PUSH_FRONT, pick_word());
		write_mode(rdq_pkg::MODE_SPARE);
		send_item(rdq_pkg::OP_PUSH_FRONT, pick_word());
		send_item(rdq_pkg::OP_POP_REAR, pick_word());

		for (int ph = 0; ph < PHASES; ph++) begin
			phase_mode = (ph < 4) ? rdq_pkg::mode_t'(ph) :
				rdq_pkg::mode_t'($urandom_range(0, 3));
			write_mode(phase_mode);
			if (ph == PHASES - 1) begin
				send_gap_pct = 0;
				stall_gap_pct = 0;
			end else begin
				send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
				stall_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Swing between filling and draining so both full and empty are reached.
				if (run_left == 0) begin
					case ($urandom_range(0, 2))
						0: push_pct = 85;
						1: push_pct = 15;
						default: push_pct = 50;
					endcase
					run_left = $urandom_range(10, 40);
				end
				run_left--;
				send_item(pick_op(push_pct), pick_word());
			end
		end

		in_valid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("restricted_double_ended_queue_core test passed");
		else
			$display("restricted_double_ended_queue_core test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/rdq_pkg.sv
rtl/restricted_double_ended_queue_core.sv
rtl/rdq_checker.sv
tb/rdq_queue_checker.sv
tb/tb.sv
